/* rtl/core/tbsc_pkg.sv */
// ============================================================================
// tbsc_pkg
// Shared types and constants of the typed buffer slot claimer: transaction
// payloads, configuration view, register map and controller/datapath links.
// ============================================================================
`default_nettype none

package tbsc_pkg;

    // field widths fixed by the interface
    localparam int TYPE_W   = 2;
    localparam int IDX_W    = 4;
    localparam int BYTES_W  = 32;
    localparam int TAG_W    = 32;
    localparam int CNT_W    = 5;
    localparam int ACTION_W = 2;

    // configuration port
    localparam int REG_TYPES = 4;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REGIDX_W  = 3;

    // a claim looks at no more than this many slots of one type
    localparam int SCAN_MAX = 16;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLAIM   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

    // register indexes
    localparam logic [REGIDX_W-1:0] REG_SIZE_TYPE0  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_SIZE_TYPE1  = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_SIZE_TYPE2  = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_SIZE_TYPE3  = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_COUNT_TYPE0 = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_COUNT_TYPE1 = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_COUNT_TYPE2 = 3'd6;
    localparam logic [REGIDX_W-1:0] REG_COUNT_TYPE3 = 3'd7;

    // request transaction
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TYPE_W-1:0]   exec_kind;
        logic [BYTES_W-1:0]  request_bytes;
        logic [TAG_W-1:0]    operator_tag;
        logic [IDX_W-1:0]    slot_index;
    } req_t;

    // response transaction
    typedef struct packed {
        logic                granted;
        logic [TYPE_W-1:0]   granted_type;
        logic [IDX_W-1:0]    granted_index;
        logic [BYTES_W-1:0]  unmet_bytes;
        logic                last;
    } rsp_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [REG_TYPES-1:0][BYTES_W-1:0] size;
        logic [REG_TYPES-1:0][CNT_W-1:0]   count;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rel;
        logic clear_all;
        logic grant;
        logic miss;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/tbsc_regs.sv */
// ============================================================================
// tbsc_regs
// APB-style configuration registers: buffer size and buffer count per type.
// ============================================================================
`default_nettype none

module tbsc_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tbsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tbsc_pkg::DATA_W-1:0]   pwdata,
    output logic      [tbsc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output tbsc_pkg::cfg_t                     cfg
);

    logic [tbsc_pkg::REG_TYPES-1:0][tbsc_pkg::BYTES_W-1:0] size_reg, size_next;
    logic [tbsc_pkg::REG_TYPES-1:0][tbsc_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [tbsc_pkg::REGIDX_W-1:0]                         reg_idx;
    logic                                                  wr_en;

    assign reg_idx = paddr[tbsc_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register write decode
    always_comb
    begin
        size_next  = size_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            case (reg_idx)
                tbsc_pkg::REG_SIZE_TYPE0:  size_next[0]  = pwdata;
                tbsc_pkg::REG_SIZE_TYPE1:  size_next[1]  = pwdata;
                tbsc_pkg::REG_SIZE_TYPE2:  size_next[2]  = pwdata;
                tbsc_pkg::REG_SIZE_TYPE3:  size_next[3]  = pwdata;
                tbsc_pkg::REG_COUNT_TYPE0: count_next[0] = pwdata[tbsc_pkg::CNT_W-1:0];
                tbsc_pkg::REG_COUNT_TYPE1: count_next[1] = pwdata[tbsc_pkg::CNT_W-1:0];
                tbsc_pkg::REG_COUNT_TYPE2: count_next[2] = pwdata[tbsc_pkg::CNT_W-1:0];
                tbsc_pkg::REG_COUNT_TYPE3: count_next[3] = pwdata[tbsc_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            size_reg  <= size_next;
            count_reg <= count_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_idx)
            tbsc_pkg::REG_SIZE_TYPE0:  prdata = size_reg[0];
            tbsc_pkg::REG_SIZE_TYPE1:  prdata = size_reg[1];
            tbsc_pkg::REG_SIZE_TYPE2:  prdata = size_reg[2];
            tbsc_pkg::REG_SIZE_TYPE3:  prdata = size_reg[3];
            tbsc_pkg::REG_COUNT_TYPE0: prdata = tbsc_pkg::DATA_W'(count_reg[0]);
            tbsc_pkg::REG_COUNT_TYPE1: prdata = tbsc_pkg::DATA_W'(count_reg[1]);
            tbsc_pkg::REG_COUNT_TYPE2: prdata = tbsc_pkg::DATA_W'(count_reg[2]);
            tbsc_pkg::REG_COUNT_TYPE3: prdata = tbsc_pkg::DATA_W'(count_reg[3]);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.size  = size_reg;
    assign cfg.count = count_reg;

endmodule

`default_nettype wire

/* rtl/core/tbsc_ctrl.sv */
// ============================================================================
// tbsc_ctrl
// Controller: takes request transactions, runs the slot scan of a claim and
// owns the response valid flag.
// ============================================================================
`default_nettype none

module tbsc_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    input  wire logic [tbsc_pkg::ACTION_W-1:0]   action,
    output logic                                 req_ready,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    input  wire tbsc_pkg::dp_status_t            status,
    output tbsc_pkg::dp_cmd_t                    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    // output register can take a new response
    assign out_free = !rsp_valid_reg || rsp_ready;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (action)
                        tbsc_pkg::ACT_CLAIM:
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        tbsc_pkg::ACT_RELEASE: cmd.rel       = 1'b1;
                        tbsc_pkg::ACT_CLEAR:   cmd.clear_all = 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (status.hit)
                    begin
                        cmd.grant = 1'b1;
                        if (status.last)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.miss   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // response valid flag
    assign rsp_valid_next = (rsp_valid_reg && !rsp_ready) || cmd.grant || cmd.miss;
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tbsc_datapath.sv */
// ============================================================================
// tbsc_datapath
// Slot table (busy flags and owner tags), claim scan registers, free-slot
// search and the response register.
// ============================================================================
`default_nettype none

module tbsc_datapath #(
    parameter int NUM_TYPES     = 4,
    parameter int BUFS_PER_KIND = 16,
    parameter int NUM_SLOTS     = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tbsc_pkg::req_t       req_data,
    input  wire tbsc_pkg::cfg_t       cfg,
    input  wire tbsc_pkg::dp_cmd_t    cmd,
    output tbsc_pkg::dp_status_t      status,
    output tbsc_pkg::rsp_t            rsp_data
);

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SPAN    = ((1 << tbsc_pkg::TYPE_W) - 1) * BUFS_PER_KIND
                             + tbsc_pkg::SCAN_MAX;
    localparam int SPAN_W  = $clog2(SPAN);
    localparam int SN_W    = (SPAN_W > SLOT_W) ? SPAN_W : SLOT_W;
    localparam int SCAN_W  = tbsc_pkg::CNT_W;

    // scan registers
    logic [tbsc_pkg::TYPE_W-1:0]  type_reg;
    logic [SN_W-1:0]              base_reg;
    logic [tbsc_pkg::BYTES_W-1:0] remain_reg;
    logic [tbsc_pkg::BYTES_W-1:0] size_reg;
    logic [tbsc_pkg::TAG_W-1:0]   tag_reg;
    logic [SCAN_W-1:0]            lim_reg;
    logic [SCAN_W-1:0]            start_reg;

    // slot table
    logic [NUM_SLOTS-1:0]         busy_reg, busy_next;
    logic [tbsc_pkg::TAG_W-1:0]   owner_mem [NUM_SLOTS];

    tbsc_pkg::rsp_t               rsp_reg;

    // load values
    logic                         type_ok;
    logic [tbsc_pkg::CNT_W-1:0]   ld_cnt;
    logic [SCAN_W-1:0]            ld_lim;

    // search
    logic [tbsc_pkg::SCAN_MAX-1:0] free_mask, cand_mask;
    logic                          hit, later;
    logic [tbsc_pkg::IDX_W-1:0]    pick;
    logic [SN_W-1:0]               grant_slot;
    logic [tbsc_pkg::BYTES_W-1:0]  take, remain_new;

    // release decode
    logic [31:0]                   rel_sum;
    logic                          rel_ok;

    // scan limit from the count register, capped by buffers per type and scan window
    assign type_ok = 32'(req_data.exec_kind) < NUM_TYPES;
    assign ld_cnt  = cfg.count[req_data.exec_kind];

    always_comb
    begin
        ld_lim = ld_cnt;
        if (32'(ld_lim) > tbsc_pkg::SCAN_MAX)
            ld_lim = SCAN_W'(tbsc_pkg::SCAN_MAX);
        if (32'(ld_lim) > BUFS_PER_KIND)
            ld_lim = SCAN_W'(BUFS_PER_KIND);
        if (!type_ok)
            ld_lim = '0;
    end

    // free slots within the scan window of the current type
    always_comb
    begin
        logic [SN_W-1:0] sj;
        sj = '0;
        for (int j = 0; j < tbsc_pkg::SCAN_MAX; j++)
        begin
            sj           = base_reg + SN_W'(j);
            free_mask[j] = (32'(j) < 32'(lim_reg)) && (32'(sj) < NUM_SLOTS)
                           && !busy_reg[sj[SLOT_W-1:0]];
            cand_mask[j] = free_mask[j] && (32'(j) >= 32'(start_reg));
        end
    end

    // lowest free slot at or past the scan position
    always_comb
    begin
        hit  = 1'b0;
        pick = '0;
        for (int j = tbsc_pkg::SCAN_MAX - 1; j >= 0; j--)
        begin
            if (cand_mask[j])
            begin
                hit  = 1'b1;
                pick = tbsc_pkg::IDX_W'(j);
            end
        end
    end

    // any free slot left beyond the picked one
    always_comb
    begin
        later = 1'b0;
        for (int j = 0; j < tbsc_pkg::SCAN_MAX; j++)
        begin
            if (free_mask[j] && (32'(j) > 32'(pick)))
                later = 1'b1;
        end
    end

    // need drops by the buffer size, saturating at zero
    assign take       = (remain_reg < size_reg) ? remain_reg : size_reg;
    assign remain_new = remain_reg - take;
    assign grant_slot = base_reg + SN_W'(pick);

    assign status.hit  = hit;
    assign status.last = (remain_new == '0) || !later;

    // release target
    assign rel_sum = 32'(req_data.exec_kind) * BUFS_PER_KIND
                     + 32'(req_data.slot_index);
    assign rel_ok  = type_ok && (32'(req_data.slot_index) < BUFS_PER_KIND)
                     && (rel_sum < NUM_SLOTS);

    // busy flag updates
    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.clear_all)
            busy_next = '0;
        if (cmd.rel && rel_ok)
            busy_next[rel_sum[SLOT_W-1:0]] = 1'b0;
        if (cmd.grant)
            busy_next[grant_slot[SLOT_W-1:0]] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= '0;
        else
            busy_reg <= busy_next;
    end

    // owner tags
    always_ff @(posedge clk)
    begin
        if (cmd.grant)
            owner_mem[grant_slot[SLOT_W-1:0]] <= tag_reg;
    end

    // claim context and scan position
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg   <= req_data.exec_kind;
            base_reg   <= SN_W'(32'(req_data.exec_kind) * BUFS_PER_KIND);
            remain_reg <= req_data.request_bytes;
            size_reg   <= cfg.size[req_data.exec_kind];
            tag_reg    <= req_data.operator_tag;
            lim_reg    <= ld_lim;
            start_reg  <= '0;
        end
        else if (cmd.grant)
        begin
            remain_reg <= remain_new;
            start_reg  <= SCAN_W'(pick) + SCAN_W'(1);
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.grant)
        begin
            rsp_reg.granted       <= 1'b1;
            rsp_reg.granted_type  <= type_reg;
            rsp_reg.granted_index <= pick;
            rsp_reg.unmet_bytes   <= remain_new;
            rsp_reg.last          <= status.last;
        end
        else if (cmd.miss)
        begin
            rsp_reg.granted       <= 1'b0;
            rsp_reg.granted_type  <= type_reg;
            rsp_reg.granted_index <= '0;
            rsp_reg.unmet_bytes   <= remain_reg;
            rsp_reg.last          <= 1'b1;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

/* rtl/core/typed_buffer_slot_claimer_unit.sv */
// ============================================================================
// typed_buffer_slot_claimer_unit
// Ownership table of fixed-size buffer slots grouped by executor type:
// claims take free slots of a type until the byte need is met or no free slot
// is left, releases and clears free slots.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------
//  req     | in        | req_valid / req_ready  | tbsc_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_ready  | tbsc_pkg::rsp_t
//  apb     | in        | psel, penable, pwrite  | paddr, pwdata, prdata
//
//  release, clear and unused actions finish in the accept cycle
//  a claim loads its context first, then grants one slot per cycle while the
//  rsp channel does not stall, or gives a single no-slot response; busy slots
//  are skipped by a combinational priority search over the sixteen-slot window
//  req_ready is high only while no claim is scanning; a stalled rsp channel
//  holds the scan, the response register keeps one transaction
//  reset clears all busy flags, the configuration registers, the controller state and the response valid flag
//
`default_nettype none

module typed_buffer_slot_claimer_unit #(
    parameter int NUM_TYPES     = 4,
    parameter int BUFS_PER_KIND = 16,
    parameter int NUM_SLOTS     = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire tbsc_pkg::req_t                req_data,

    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output tbsc_pkg::rsp_t                     rsp_data,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tbsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tbsc_pkg::DATA_W-1:0]   pwdata,
    output logic      [tbsc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    tbsc_pkg::cfg_t       cfg;
    tbsc_pkg::dp_cmd_t    cmd;
    tbsc_pkg::dp_status_t status;

    // configuration registers
    tbsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    tbsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (req_data.action),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    tbsc_datapath #(
        .NUM_TYPES     (NUM_TYPES),
        .BUFS_PER_KIND (BUFS_PER_KIND),
        .NUM_SLOTS     (NUM_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire
